// ===== sv/sha512_hash_engine_defines.svh =====
// Assertion macros for the SHA-512 engine checker.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH
// check that prop holds on every clock edge outside reset
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check that cond never holds
`define SHA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

// ===== sv/sha512_pkg.sv =====
// Shared types, constants and round functions of the SHA-512 engine.
// No dependencies.
package sha512_pkg;

  typedef struct packed {
    logic [63:0] word;
    logic        final_word;
  } blk_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [63:0] init_hash(input logic [2:0] idx);
    logic [63:0] r;
    case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] r;
    case (t)
      7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sig0(input logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sig1(input logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] sml_sig0(input logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sml_sig1(input logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ===== sv/sha512_front.sv =====
// Front end: takes message words, counts the length and emits the padded
// block word stream. Depends on sha512_pkg.
module sha512_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [63:0]           message_word_i,
  input  logic [3:0]            byte_count_i,
  input  logic                  last_word_i,
  output logic                  push_valid_o,
  input  sha512_pkg::q_stat_t   q_stat_i,
  output sha512_pkg::blk_word_t push_data_o
);
  import sha512_pkg::*;

  localparam logic [1:0] ST_TAKE = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_LEN  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [3:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  nb;
  logic [63:0] pad_word;
  logic        push_ok;

  assign nb      = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;
  assign push_ok = !q_stat_i.full;
  assign in_ready_o = (st_q == ST_TAKE) && push_ok;

  // keep the valid leading bytes, put the 0x80 byte right after them
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nb) begin
        pad_word[63-8*b -: 8] = message_word_i[63-8*b -: 8];
      end else if (4'(b) == nb) begin
        pad_word[63-8*b -: 8] = 8'h80;
      end else begin
        pad_word[63-8*b -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    st_d         = st_q;
    fill_d       = fill_q;
    len_d        = len_q;
    push_valid_o = 1'b0;
    push_data_o  = '{word: '0, final_word: 1'b0};
    unique case (st_q)
      ST_TAKE: begin
        if (in_valid_i && push_ok) begin
          push_valid_o = 1'b1;
          fill_d       = fill_q + 4'd1;
          if (!last_word_i) begin
            push_data_o.word = message_word_i;
            len_d            = len_q + 64'd64;
          end else begin
            len_d = len_q + {57'd0, nb, 3'd0};
            if (nb == 4'd8) begin
              push_data_o.word = message_word_i;
              st_d             = ST_MARK;
            end else begin
              push_data_o.word = pad_word;
              st_d             = ST_ZERO;
            end
          end
        end
      end
      ST_MARK: begin
        if (push_ok) begin
          push_valid_o     = 1'b1;
          push_data_o.word = 64'h8000_0000_0000_0000;
          fill_d           = fill_q + 4'd1;
          st_d             = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (push_ok) begin
          push_valid_o = 1'b1;
          fill_d       = fill_q + 4'd1;
          if (fill_q == 4'd14) st_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (push_ok) begin
          push_valid_o           = 1'b1;
          push_data_o.word       = len_q;
          push_data_o.final_word = 1'b1;
          fill_d                 = '0;
          len_d                  = '0;
          st_d                   = ST_TAKE;
        end
      end
      default: st_d = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_TAKE;
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      st_q   <= st_d;
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

endmodule

// ===== sv/sha512_fifo.sv =====
// Four-entry word queue between front and back end.
// Depends on sha512_pkg.
module sha512_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sha512_pkg::blk_word_t push_data_i,
  input  logic                  pop_i,
  output sha512_pkg::blk_word_t pop_data_o,
  output sha512_pkg::q_stat_t   stat_o
);
  import sha512_pkg::*;

  blk_word_t  mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.empty = (cnt_q == 3'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 2'd1;
      if (do_pop)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, do_push} - {2'd0, do_pop};
    end
  end

endmodule

// ===== sv/sha512_back.sv =====
// Back end: loads 16-word blocks, runs 80 rounds, emits the digest.
// Depends on sha512_pkg.
module sha512_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha512_pkg::q_stat_t   q_stat_i,
  input  sha512_pkg::blk_word_t pop_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [63:0]           digest_word_o,
  output logic                  digest_last_o
);
  import sha512_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  st_q;
  logic [3:0]  cnt_q;
  logic [6:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        fin_q;
  logic [63:0] w_q [16];
  logic [63:0] v_q [8];
  logic [63:0] h_q [8];
  logic        ovalid_q, olast_q;
  logic [63:0] oword_q;
  logic [63:0] w_new, t1, t2;
  logic        load_out;

  assign pop_o         = (st_q == ST_LOAD) && !q_stat_i.empty;
  assign out_valid_o   = ovalid_q;
  assign digest_word_o = oword_q;
  assign digest_last_o = olast_q;
  assign load_out      = (st_q == ST_OUT) && (!ovalid_q || out_ready_i);

  assign w_new = sml_sig1(w_q[14]) + w_q[9] + sml_sig0(w_q[1]) + w_q[0];
  assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + round_k(rnd_q) + w_q[0];
  assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= pop_data_i.word;
      if (cnt_q == 4'd15) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end else if (st_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      oword_q <= h_q[idx_q];
      olast_q <= (idx_q == 3'd7);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_LOAD;
      cnt_q    <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        ST_LOAD: begin
          if (pop_o) begin
            cnt_q <= cnt_q + 4'd1;
            fin_q <= pop_data_i.final_word;
            if (cnt_q == 4'd15) begin
              rnd_q <= '0;
              st_q  <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) st_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          idx_q <= '0;
          st_q  <= fin_q ? ST_OUT : ST_LOAD;
        end
        ST_OUT: begin
          if (load_out) begin
            ovalid_q <= 1'b1;
            idx_q    <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
              st_q <= ST_LOAD;
            end
          end
        end
        default: st_q <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== sv/sha512_hash_engine.sv =====
// SHA-512 hash engine, top level.
// Channels: input words (message_word_i, byte_count_i, last_word_i) under
// in_valid_i/in_ready_o; digest words (digest_word_o, digest_last_o) under
// out_valid_o/out_ready_i. Each channel moves one word per handshake.
// Only the word flagged last_word_i may be partial; byte_count_i above 8
// counts as 8. After the last word the engine pads the message and returns
// the eight digest words, H0 first, digest_last_o on the eighth.
// Throughput: the front end takes one word per cycle into a 4-deep queue
// while it is not padding and the queue is not full; the back end loads a
// 16-word block, runs 80 rounds (one round per cycle) and adds into the
// hash, popping no new word until the rounds and the addition are done.
// After the last word the back end compresses the padding block(s); the
// first digest word then passes through the output register.
// Reset: clears queue and counters and loads the initial hash vector; the
// hash is reloaded after every digest.
// Stall: a stalled receiver holds the digest word; the back end waits, and
// once the queue fills the input channel deasserts in_ready_o.
// Depends on sha512_pkg, sha512_front, sha512_fifo, sha512_back.
module sha512_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic        digest_last_o
);
  import sha512_pkg::*;

  blk_word_t push_data, pop_data;
  q_stat_t   q_stat;
  logic      push_valid, pop;

  sha512_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .message_word_i,
    .byte_count_i,
    .last_word_i,
    .push_valid_o (push_valid),
    .q_stat_i     (q_stat),
    .push_data_o  (push_data)
  );

  sha512_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push_valid),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  sha512_back u_back (
    .clk_i,
    .rst_ni,
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .digest_word_o,
    .digest_last_o
  );

endmodule

// ===== sv/sha512_hash_engine_chk.sv =====
// Port-level checker for the SHA-512 engine, bound to the top level.
// Depends on sha512_hash_engine_defines.svh.
`include "sha512_hash_engine_defines.svh"
module sha512_hash_engine_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [63:0] message_word_i,
  input logic [3:0]  byte_count_i,
  input logic        last_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] digest_word_o,
  input logic        digest_last_o
);

  `SHA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "digest word dropped")
  `SHA_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(digest_word_o), "digest word changed")
  // digest words stream without gaps until the eighth
  `SHA_ASSERT(a_burst, out_valid_o && out_ready_i && !digest_last_o |=> out_valid_o, "gap in digest")
  // a new digest needs at least one compression after the last one
  `SHA_ASSERT(a_gap, out_valid_o && out_ready_i && digest_last_o |=> !out_valid_o, "digest too early")
  `SHA_NEVER(a_x_ready, $isunknown(in_ready_o), "in_ready_o unknown")

endmodule

bind sha512_hash_engine sha512_hash_engine_chk u_chk (.*);
